### rtl/core/ptb_pkg.sv
// Package for the periodic timer bank: sizes, request kind codes and payload types.
// No dependencies; used by every module under rtl/core.
package ptb_pkg;

  localparam int NUM_TIMERS = 16;
  localparam int SLOT_W     = 4;
  localparam int SLOT_CAP   = 1 << SLOT_W;
  localparam int USED_SLOTS = (NUM_TIMERS < SLOT_CAP) ? NUM_TIMERS : SLOT_CAP;
  localparam int IDX_W      = (USED_SLOTS > 1) ? $clog2(USED_SLOTS) : 1;
  localparam int CNT_W      = $clog2(USED_SLOTS + 1);
  localparam int DATA_W     = 32;

  localparam logic [SLOT_W:0] SLOT_LIMIT = (SLOT_W + 1)'(USED_SLOTS);
  localparam logic [CNT_W-1:0] SCAN_END  = CNT_W'(USED_SLOTS);

  localparam logic [2:0] KIND_TICK    = 3'd0;
  localparam logic [2:0] KIND_START   = 3'd1;
  localparam logic [2:0] KIND_DELETE  = 3'd2;
  localparam logic [2:0] KIND_RELOAD  = 3'd3;
  localparam logic [2:0] KIND_ELAPSED = 3'd4;
  localparam logic [2:0] KIND_REMAIN  = 3'd5;
  localparam logic [2:0] KIND_MARK    = 3'd6;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  typedef struct packed {
    logic [2:0]        kind;
    logic [SLOT_W-1:0] timer_slot;
    logic [DATA_W-1:0] timer_period;
    logic [DATA_W-1:0] mark_tick;
  } in_t;

  typedef struct packed {
    logic              status;
    logic              expired;
    logic [SLOT_W-1:0] result_slot;
    logic [DATA_W-1:0] result_value;
    logic              last;
  } out_t;

endpackage

### rtl/core/ptb_mem.sv
// Period and count storage for the timer slots, one shared address, registered read.
// Depends on ptb_pkg.
module ptb_mem
  import ptb_pkg::*;
(
  input  logic              clk,
  input  logic [IDX_W-1:0]  addr,
  input  logic              we_period,
  input  logic              we_count,
  input  logic [DATA_W-1:0] wr_period,
  input  logic [DATA_W-1:0] wr_count,
  output logic [DATA_W-1:0] rd_period,
  output logic [DATA_W-1:0] rd_count
);

  logic [DATA_W-1:0] period_mem [USED_SLOTS];
  logic [DATA_W-1:0] count_mem  [USED_SLOTS];

  always_ff @(posedge clk) begin
    if (we_period) begin
      period_mem[addr] <= wr_period;
    end
    if (we_count) begin
      count_mem[addr] <= wr_count;
    end
    rd_period <= period_mem[addr];
    rd_count  <= count_mem[addr];
  end

endmodule

### rtl/core/ptb_alu.sv
// Shared 32-bit adder with carry-in and carry-out; serves increments, subtracts and compares.
// Depends on ptb_pkg.
module ptb_alu
  import ptb_pkg::*;
(
  input  logic [DATA_W-1:0] op_a,
  input  logic [DATA_W-1:0] op_b,
  input  logic              cin,
  output logic [DATA_W-1:0] sum,
  output logic              carry
);

  assign {carry, sum} = {1'b0, op_a} + {1'b0, op_b} + {{DATA_W{1'b0}}, cin};

endmodule

### rtl/core/periodic_timer_bank.sv
// Periodic timer bank top level: request sequencer, live bits and system tick.
// Depends on ptb_pkg, ptb_mem and ptb_alu.
//
// Usage: requests arrive on in_valid/in_ready/in_data (kind, timer_slot,
// timer_period, mark_tick); results leave on out_valid/out_ready/out_data.
// Every request ends with one result that has last set. A tick request first
// gives one expiry result per slot whose count reached its period, in slot
// order, then a final result carrying the new system tick.
// in_ready is high only while the sequencer is idle; one request is handled at
// a time. Delete, reload and unknown kinds go straight to the output
// register; elapsed and remaining first read a live slot, ticks-since-mark
// first completes its subtraction, and start first scans for a free slot. A
// tick skips free slots and takes each live one through read, increment and
// compare against period (single shared adder), emitting any expiry before it moves on.
// The output register frees the input side: a new request is taken while a
// result still waits. When the receiver stalls, the sequencer holds at its
// next result until the output register drains.
// Reset (rst_n low, synchronous) frees every slot and clears the system tick;
// period and count storage needs no clearing.
module periodic_timer_bank
  import ptb_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_MARK,
    S_EMIT,
    S_SSCAN,
    S_TSCAN,
    S_TINC,
    S_TCMP,
    S_TEXP
  } state_t;

  state_t                  state_r;
  logic [USED_SLOTS-1:0]   live_r;
  logic [DATA_W-1:0]       sys_tick_r;
  logic [CNT_W-1:0]        idx_r;
  logic [2:0]              kind_r;
  logic [DATA_W-1:0]       period_r;
  logic [DATA_W-1:0]       mark_r;
  logic [DATA_W-1:0]       inc_r;
  logic                    carry_r;
  out_t                    res_r;
  logic                    out_valid_r;
  out_t                    out_data_r;

  logic [IDX_W-1:0]  in_idx;
  logic [IDX_W-1:0]  scan_idx;
  logic              in_slot_live;
  logic              in_fire;
  logic              out_free;
  logic              scan_done;
  logic [IDX_W-1:0]  mem_addr;
  logic              mem_we_period;
  logic              mem_we_count;
  logic [DATA_W-1:0] mem_wr_period;
  logic [DATA_W-1:0] mem_wr_count;
  logic [DATA_W-1:0] rd_period;
  logic [DATA_W-1:0] rd_count;
  logic [DATA_W-1:0] alu_a;
  logic [DATA_W-1:0] alu_b;
  logic              alu_cin;
  logic [DATA_W-1:0] alu_sum;
  logic              alu_carry;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || out_ready;

  assign in_idx       = in_data.timer_slot[IDX_W-1:0];
  assign scan_idx     = idx_r[IDX_W-1:0];
  assign scan_done    = (idx_r == SCAN_END);
  assign in_slot_live = ({1'b0, in_data.timer_slot} < SLOT_LIMIT) && live_r[in_idx];

  always_comb begin
    mem_addr      = (state_r == S_IDLE) ? in_idx : scan_idx;
    mem_wr_period = (state_r == S_IDLE) ? in_data.timer_period : period_r;
    mem_wr_count  = (state_r == S_TCMP && !alu_carry) ? inc_r : '0;
    mem_we_period = 1'b0;
    mem_we_count  = 1'b0;
    if (in_fire && in_data.kind == KIND_RELOAD && in_slot_live) begin
      mem_we_period = 1'b1;
      mem_we_count  = 1'b1;
    end
    if (state_r == S_SSCAN && !scan_done && !live_r[scan_idx]) begin
      mem_we_period = 1'b1;
      mem_we_count  = 1'b1;
    end
    if (state_r == S_TCMP) begin
      mem_we_count = 1'b1;
    end
  end

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_cin = 1'b1;
    case (state_r)
      S_IDLE: begin
        alu_a = sys_tick_r;
        alu_b = ~in_data.mark_tick;
      end
      S_RD: begin
        alu_a = rd_period;
        alu_b = ~rd_count;
      end
      S_MARK: begin
        alu_a   = sys_tick_r;
        alu_b   = ~mark_r;
        alu_cin = carry_r;
      end
      S_TSCAN: begin
        alu_a = sys_tick_r;
      end
      S_TINC: begin
        alu_a = rd_count;
      end
      S_TCMP: begin
        alu_a = inc_r;
        alu_b = ~rd_period;
      end
      default: begin
        alu_cin = 1'b0;
      end
    endcase
  end

  ptb_mem u_mem (
    .clk       (clk),
    .addr      (mem_addr),
    .we_period (mem_we_period),
    .we_count  (mem_we_count),
    .wr_period (mem_wr_period),
    .wr_count  (mem_wr_count),
    .rd_period (rd_period),
    .rd_count  (rd_count)
  );

  ptb_alu u_alu (
    .op_a  (alu_a),
    .op_b  (alu_b),
    .cin   (alu_cin),
    .sum   (alu_sum),
    .carry (alu_carry)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      live_r      <= '0;
      sys_tick_r  <= '0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      if (out_valid_r && out_ready && !(state_r inside {S_EMIT, S_TEXP})) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            kind_r   <= in_data.kind;
            period_r <= in_data.timer_period;
            mark_r   <= in_data.mark_tick;
            carry_r  <= alu_carry;
            idx_r    <= '0;
            res_r    <= '{status: (in_slot_live &&
                                   (in_data.kind inside {KIND_DELETE, KIND_RELOAD}))
                                  ? STATUS_OK : STATUS_FAIL,
                          expired: 1'b0, result_slot: '0,
                          result_value: '0, last: 1'b1};
            case (in_data.kind)
              KIND_TICK:  state_r <= S_TSCAN;
              KIND_START: state_r <= S_SSCAN;
              KIND_MARK:  state_r <= S_MARK;
              KIND_DELETE: begin
                if (in_slot_live) begin
                  live_r[in_idx] <= 1'b0;
                end
                state_r <= S_EMIT;
              end
              KIND_ELAPSED, KIND_REMAIN: begin
                state_r <= in_slot_live ? S_RD : S_EMIT;
              end
              default: state_r <= S_EMIT;
            endcase
          end
        end
        S_RD: begin
          if (kind_r == KIND_ELAPSED) begin
            res_r.status       <= STATUS_OK;
            res_r.result_value <= rd_count;
          end else if (alu_carry) begin
            res_r.status       <= STATUS_OK;
            res_r.result_value <= alu_sum;
          end
          state_r <= S_EMIT;
        end
        S_MARK: begin
          res_r.status       <= STATUS_OK;
          res_r.result_value <= alu_sum;
          state_r            <= S_EMIT;
        end
        S_SSCAN: begin
          if (scan_done) begin
            state_r <= S_EMIT;
          end else if (!live_r[scan_idx]) begin
            live_r[scan_idx]  <= 1'b1;
            res_r.status      <= STATUS_OK;
            res_r.result_slot <= SLOT_W'(idx_r);
            state_r           <= S_EMIT;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_TSCAN: begin
          if (scan_done) begin
            sys_tick_r         <= alu_sum;
            res_r.status       <= STATUS_OK;
            res_r.result_value <= alu_sum;
            state_r            <= S_EMIT;
          end else if (live_r[scan_idx]) begin
            state_r <= S_TINC;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_TINC: begin
          inc_r   <= alu_sum;
          state_r <= S_TCMP;
        end
        S_TCMP: begin
          if (alu_carry) begin
            state_r <= S_TEXP;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_TSCAN;
          end
        end
        S_TEXP: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_data_r  <= '{status: STATUS_OK, expired: 1'b1,
                             result_slot: SLOT_W'(idx_r), result_value: '0,
                             last: 1'b0};
            idx_r       <= idx_r + 1'b1;
            state_r     <= S_TSCAN;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_data_r  <= res_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

### bench/periodic_timer_bank_tb.sv
// Testbench for periodic_timer_bank: a directed table of requests, then random
// episodes, all scored against an in-bench model of the timer slots and system tick.
// Depends on ptb_pkg and the periodic_timer_bank RTL.
module periodic_timer_bank_tb
  import ptb_pkg::*;
();

  localparam logic [2:0]        KIND_UNKNOWN = 3'd7;
  localparam logic [DATA_W-1:0] WRAP_MAX     = 32'hFFFF_FFFF;
  localparam int                RANDOM_ITEMS = 220;
  localparam int                EPISODE_LEN  = 40;

  typedef enum logic [1:0] {EP_MIXED, EP_FILL, EP_DRAIN} episode_t;

  typedef struct {
    in_t  req;
    bit   typed;
    out_t result;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  bit              timer_live   [SLOT_CAP];
  bit [DATA_W-1:0] timer_reload [SLOT_CAP];
  bit [DATA_W-1:0] timer_count  [SLOT_CAP];
  bit [DATA_W-1:0] bank_tick = '0;
  out_t            pending_results [$];

  int unsigned failures = 0;
  int unsigned stall_left = 0;
  bit          feeder_calm = 1'b0;
  bit          sink_calm = 1'b0;

  periodic_timer_bank DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #4_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic out_t make_result(input logic status, input logic expired,
                                       input int unsigned slot,
                                       input logic [DATA_W-1:0] value, input logic last);
    out_t r;
    r.status       = status;
    r.expired      = expired;
    r.result_slot  = SLOT_W'(slot);
    r.result_value = value;
    r.last         = last;
    return r;
  endfunction

  task automatic advance_bank(input in_t req);
    bit   slot_ok;
    bit   granted;
    out_t fail_result;
    fail_result = make_result(STATUS_FAIL, 1'b0, 0, '0, 1'b1);
    slot_ok = (req.timer_slot < USED_SLOTS) && timer_live[req.timer_slot];
    granted = 1'b0;
    case (req.kind)
      KIND_TICK: begin
        for (int i = 0; i < USED_SLOTS; i++) begin
          if (timer_live[i]) begin
            timer_count[i] = timer_count[i] + 1'b1;
            if (timer_count[i] >= timer_reload[i]) begin
              timer_count[i] = '0;
              pending_results.push_back(make_result(STATUS_OK, 1'b1, i, '0, 1'b0));
            end
          end
        end
        bank_tick = bank_tick + 1'b1;
        pending_results.push_back(make_result(STATUS_OK, 1'b0, 0, bank_tick, 1'b1));
      end
      KIND_START: begin
        for (int i = 0; i < USED_SLOTS; i++) begin
          if (!granted && !timer_live[i]) begin
            granted = 1'b1;
            timer_live[i] = 1'b1;
            timer_reload[i] = req.timer_period;
            timer_count[i] = '0;
            pending_results.push_back(make_result(STATUS_OK, 1'b0, i, '0, 1'b1));
          end
        end
        if (!granted) pending_results.push_back(fail_result);
      end
      KIND_DELETE: begin
        if (!slot_ok) begin
          pending_results.push_back(fail_result);
        end else begin
          timer_live[req.timer_slot] = 1'b0;
          pending_results.push_back(make_result(STATUS_OK, 1'b0, 0, '0, 1'b1));
        end
      end
      KIND_RELOAD: begin
        if (!slot_ok) begin
          pending_results.push_back(fail_result);
        end else begin
          timer_reload[req.timer_slot] = req.timer_period;
          timer_count[req.timer_slot] = '0;
          pending_results.push_back(make_result(STATUS_OK, 1'b0, 0, '0, 1'b1));
        end
      end
      KIND_ELAPSED: begin
        if (!slot_ok) begin
          pending_results.push_back(fail_result);
        end else begin
          pending_results.push_back(make_result(STATUS_OK, 1'b0, 0,
                                                timer_count[req.timer_slot], 1'b1));
        end
      end
      KIND_REMAIN: begin
        if (!slot_ok || timer_reload[req.timer_slot] < timer_count[req.timer_slot]) begin
          pending_results.push_back(fail_result);
        end else begin
          pending_results.push_back(make_result(STATUS_OK, 1'b0, 0,
              timer_reload[req.timer_slot] - timer_count[req.timer_slot], 1'b1));
        end
      end
      KIND_MARK: begin
        if (bank_tick < req.mark_tick) begin
          pending_results.push_back(make_result(STATUS_OK, 1'b0, 0,
              bank_tick + (WRAP_MAX - req.mark_tick), 1'b1));
        end else begin
          pending_results.push_back(make_result(STATUS_OK, 1'b0, 0,
              bank_tick - req.mark_tick, 1'b1));
        end
      end
      default: begin
        pending_results.push_back(fail_result);
      end
    endcase
  endtask

  task automatic compare_field(input string name, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      failures++;
    end
  endtask

  task automatic check_result(input out_t got);
    out_t want;
    if (pending_results.size() == 0) begin
      $error("result with nothing pending: status %0d expired %0d slot %0d value %0h last %0d",
             got.status, got.expired, got.result_slot, got.result_value, got.last);
      failures++;
    end else begin
      want = pending_results.pop_front();
      compare_field("status", DATA_W'(want.status), DATA_W'(got.status));
      compare_field("expired", DATA_W'(want.expired), DATA_W'(got.expired));
      compare_field("result_slot", DATA_W'(want.result_slot), DATA_W'(got.result_slot));
      compare_field("result_value", want.result_value, got.result_value);
      compare_field("last", DATA_W'(want.last), DATA_W'(got.last));
    end
  endtask

  always @(posedge clk) begin : result_sink
    int unsigned stall;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && out_ready) begin
      check_result(out_data);
      if ($urandom_range(0, 24) == 0) sink_calm = !sink_calm;
      stall = sink_calm ? 0 : $urandom_range(0, 13);
      stall_left <= stall;
      out_ready <= (stall == 0);
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= (stall_left == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_request(input in_t req, input bit typed, input out_t typed_result);
    int unsigned gap;
    gap = feeder_calm ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
    advance_bank(req);
    if (typed) begin
      void'(pending_results.pop_back());
      pending_results.push_back(typed_result);
    end
  endtask

  function automatic directed_row_t row(input logic [2:0] kind, input int unsigned slot,
                                        input logic [DATA_W-1:0] period,
                                        input logic [DATA_W-1:0] mark, input bit typed,
                                        input logic status, input int unsigned rslot,
                                        input logic [DATA_W-1:0] value);
    directed_row_t r;
    r.req.kind         = kind;
    r.req.timer_slot   = SLOT_W'(slot);
    r.req.timer_period = period;
    r.req.mark_tick    = mark;
    r.typed            = typed;
    r.result           = make_result(status, 1'b0, rslot, value, 1'b1);
    return r;
  endfunction

  function automatic logic [SLOT_W-1:0] pick_slot();
    int live_list [$];
    for (int i = 0; i < USED_SLOTS; i++) begin
      if (timer_live[i]) live_list.push_back(i);
    end
    if (live_list.size() != 0 && $urandom_range(0, 9) < 8)
      return SLOT_W'(live_list[$urandom_range(0, live_list.size() - 1)]);
    return SLOT_W'($urandom_range(0, SLOT_CAP - 1));
  endfunction

  function automatic in_t random_request(input episode_t episode);
    in_t         req;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    req.timer_slot = pick_slot();
    req.timer_period = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 6);
    req.mark_tick = ($urandom_range(0, 2) == 0) ? $urandom
                                                : bank_tick + $urandom_range(0, 6) - 3;
    case (episode)
      EP_FILL: begin
        req.kind = (roll < 75) ? KIND_START : (roll < 90) ? KIND_TICK : KIND_ELAPSED;
      end
      EP_DRAIN: begin
        req.kind = (roll < 45) ? KIND_DELETE : (roll < 75) ? KIND_TICK : KIND_REMAIN;
      end
      default: begin
        if (roll < 30)      req.kind = KIND_TICK;
        else if (roll < 42) req.kind = KIND_START;
        else if (roll < 52) req.kind = KIND_DELETE;
        else if (roll < 62) req.kind = KIND_RELOAD;
        else if (roll < 72) req.kind = KIND_ELAPSED;
        else if (roll < 82) req.kind = KIND_REMAIN;
        else if (roll < 94) req.kind = KIND_MARK;
        else                req.kind = 3'($urandom_range(0, 7));
      end
    endcase
    return req;
  endfunction

  initial begin : stimulus
    directed_row_t rows [$];
    episode_t      episode;
    in_t           req;
    out_t          no_result;
    no_result = '0;
    episode = EP_FILL;
    //                kind          slot period        mark          typed  status       slot value
    rows.push_back(row(KIND_TICK,    0,   32'd0,        32'd0,        1'b1, STATUS_OK,   0, 32'd1));
    rows.push_back(row(KIND_ELAPSED, 0,   32'd0,        32'd0,        1'b1, STATUS_FAIL, 0, 32'd0));
    rows.push_back(row(KIND_REMAIN,  15,  32'd0,        32'd0,        1'b1, STATUS_FAIL, 0, 32'd0));
    rows.push_back(row(KIND_DELETE,  3,   32'd0,        32'd0,        1'b1, STATUS_FAIL, 0, 32'd0));
    rows.push_back(row(KIND_RELOAD,  0,   32'd7,        32'd0,        1'b1, STATUS_FAIL, 0, 32'd0));
    rows.push_back(row(KIND_MARK,    0,   32'd0,        32'd0,        1'b1, STATUS_OK,   0, 32'd1));
    rows.push_back(row(KIND_MARK,    0,   32'd0,        WRAP_MAX,     1'b1, STATUS_OK,   0, 32'd1));
    rows.push_back(row(KIND_MARK,    0,   32'd0,        32'd5,        1'b1, STATUS_OK,   0,
                       32'hFFFF_FFFB));
    rows.push_back(row(KIND_UNKNOWN, 15,  WRAP_MAX,     WRAP_MAX,     1'b1, STATUS_FAIL, 0, 32'd0));
    rows.push_back(row(KIND_START,   0,   32'd0,        32'd0,        1'b1, STATUS_OK,   0, 32'd0));
    rows.push_back(row(KIND_START,   0,   WRAP_MAX,     32'd0,        1'b1, STATUS_OK,   1, 32'd0));
    rows.push_back(row(KIND_START,   9,   32'd2,        32'd0,        1'b1, STATUS_OK,   2, 32'd0));
    rows.push_back(row(KIND_TICK,    0,   32'd0,        32'd0,        1'b0, STATUS_OK,   0, 32'd0));
    rows.push_back(row(KIND_ELAPSED, 1,   32'd0,        32'd0,        1'b0, STATUS_OK,   0, 32'd0));
    rows.push_back(row(KIND_REMAIN,  1,   32'd0,        32'd0,        1'b0, STATUS_OK,   0, 32'd0));
    rows.push_back(row(KIND_TICK,    0,   32'd0,        32'd0,        1'b0, STATUS_OK,   0, 32'd0));
    rows.push_back(row(KIND_RELOAD,  2,   32'd1,        32'd0,        1'b1, STATUS_OK,   0, 32'd0));
    rows.push_back(row(KIND_DELETE,  1,   32'd0,        32'd0,        1'b1, STATUS_OK,   0, 32'd0));
    rows.push_back(row(KIND_START,   6,   32'd3,        32'd0,        1'b1, STATUS_OK,   1, 32'd0));
    rows.push_back(row(KIND_TICK,    0,   32'd0,        32'd0,        1'b0, STATUS_OK,   0, 32'd0));
    rows.push_back(row(KIND_REMAIN,  1,   32'd0,        32'd0,        1'b0, STATUS_OK,   0, 32'd0));
    rows.push_back(row(KIND_MARK,    0,   32'd0,        32'd2,        1'b0, STATUS_OK,   0, 32'd0));
    rows.push_back(row(KIND_DELETE,  0,   32'd0,        32'd0,        1'b1, STATUS_OK,   0, 32'd0));
    rows.push_back(row(KIND_TICK,    0,   32'd0,        32'd0,        1'b0, STATUS_OK,   0, 32'd0));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (rows[k]) send_request(rows[k].req, rows[k].typed, rows[k].result);

    // open with a fill episode so the bank runs out of free slots
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % EPISODE_LEN == 0) begin
        episode = (n == 0) ? EP_FILL : episode_t'($urandom_range(0, 2));
        feeder_calm = ($urandom_range(0, 3) == 0);
      end
      req = random_request(episode);
      send_request(req, 1'b0, no_result);
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (4 * NUM_TIMERS) @(posedge clk);
    if (failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### periodic_timer_bank.f
rtl/core/ptb_pkg.sv
rtl/core/ptb_mem.sv
rtl/core/ptb_alu.sv
rtl/core/periodic_timer_bank.sv
bench/periodic_timer_bank_tb.sv
